// File: design/mbe_pkg.sv
// Package: constants, widths and saturation helper for the Mandelbrot escape-time block.
package mbe_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int COUNT_BITS  = 16;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int LIMIT_W     = 16;
  localparam int SHIFT_W     = PROD_W - FRAC_BITS + 1;
  localparam int SUM_W       = PROD_W - FRAC_BITS + 3;

  localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(10000);
  localparam logic [PROD_W-1:0]     ESC_BOUND   = PROD_W'(4) << FRAC_BITS;

  // Clamp a wide signed sum into the signed data range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (!v[SUM_W-1] && (|v[SUM_W-2:DATA_W-1])) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:DATA_W-1])) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/mandelbrot_escape_time_top.sv
// Top level: Mandelbrot escape-time iterator with one shared 32x32 multiplier.
//
// Input channel (in_valid_i / in_stall_o) carries one point c as c_real_i and
// c_imag_i, signed fixed point with FRAC_BITS fraction bits. A request is taken
// when valid is high and stall is low; stall stays high while a point is in work.
// Output channel (out_valid_o / out_stall_i) returns iteration_count_o and
// escaped_o from an output register; a result waits there while stalled.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes iteration_limit;
// write it only while the block is idle. Reset sets the limit to 10000.
// Each iteration of z = z*z + c steps through S_RR, S_II, S_CHK, S_RI and
// S_UPD: the single multiplier forms zr*zr, then zi*zi, the escape test
// follows, then zr*zi is formed while zr is updated, and zi is updated last.
// A new point is taken only once the previous result has entered the output
// register and the sequencer is back in idle. A full result register under
// stall holds the sequencer in its final state until taken.
// Reset (rst_ni low, asynchronous) empties the output and returns to idle.
module mandelbrot_escape_time_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [mbe_pkg::DATA_W-1:0]     c_real_i,
  input  logic signed [mbe_pkg::DATA_W-1:0]     c_imag_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [15:0]                    iteration_count_o,
  output logic                                  escaped_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [mbe_pkg::LIMIT_W-1:0]    cfg_data_i
);
  import mbe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RR   = 3'd1;
  localparam logic [2:0] S_II   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_RI   = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]                     state_q, state_d;
  logic [COUNT_BITS-1:0]          limit_q;
  logic [COUNT_BITS-1:0]          count_q, count_d;
  logic signed [DATA_W-1:0]       cr_q, ci_q;
  logic signed [DATA_W-1:0]       zr_q, zr_d, zi_q, zi_d;
  logic signed [PROD_W-1:0]       rr_q, ii_q, ri_q;
  logic                           esc_q, esc_d;
  logic                           out_valid_q;
  logic [COUNT_BITS-1:0]          out_count_q;
  logic                           out_esc_q;

  logic signed [DATA_W-1:0]       mul_a, mul_b;
  logic signed [PROD_W-1:0]       prod;
  logic        [PROD_W-1:0]       mag_sq;
  logic                           reach_four;
  logic signed [PROD_W-1:0]       diff;
  logic signed [SHIFT_W-1:0]      nr_sh, ni_sh;
  logic signed [SUM_W-1:0]        nr_sum, ni_sum;
  logic                           out_free;

  // Shared multiplier: operands picked by sequencer step
  assign mul_a = (state_q == S_II) ? zi_q : zr_q;
  assign mul_b = (state_q == S_RR) ? zr_q : zi_q;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Escape test on |z|^2 at full width
  assign mag_sq     = rr_q + ii_q;
  assign reach_four = (mag_sq >> FRAC_BITS) >= ESC_BOUND;

  // New z parts: floor shift, add c, clamp
  assign diff   = rr_q - ii_q;
  assign nr_sh  = SHIFT_W'(diff >>> FRAC_BITS);
  assign ni_sh  = SHIFT_W'(ri_q >>> (FRAC_BITS - 1));
  assign nr_sum = SUM_W'(nr_sh) + SUM_W'(cr_q);
  assign ni_sum = SUM_W'(ni_sh) + SUM_W'(ci_q);

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    esc_d   = esc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RR;
          count_d = '0;
          zr_d    = '0;
          zi_d    = '0;
          esc_d   = 1'b0;
        end
      end
      S_RR:  state_d = S_II;
      S_II:  state_d = S_CHK;
      S_CHK: begin
        if (count_q != '0 && reach_four) begin
          esc_d   = 1'b1;
          state_d = S_DONE;
        end else if (count_q >= limit_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RI;
        end
      end
      S_RI: begin
        zr_d    = sat_data(nr_sum);
        state_d = S_UPD;
      end
      S_UPD: begin
        zi_d    = sat_data(ni_sum);
        count_d = count_q + COUNT_BITS'(1);
        state_d = S_RR;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) limit_q <= cfg_data_i[COUNT_BITS-1:0];
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    esc_q   <= esc_d;
    if (state_q == S_IDLE && in_valid_i) begin
      cr_q <= c_real_i;
      ci_q <= c_imag_i;
    end
    if (state_q == S_RR) rr_q <= prod;
    if (state_q == S_II) ii_q <= prod;
    if (state_q == S_RI) ri_q <= prod;
    if (state_q == S_DONE && out_free) begin
      out_count_q <= count_q;
      out_esc_q   <= esc_q;
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = 16'(out_count_q);
  assign escaped_o         = out_esc_q;

endmodule
